/* hw/rtl/bcd_pkg.sv */
// Shared types, codes and tone tables for the byte command decoder.
// No dependencies; every other file in hw/rtl refers to this package.
package bcd_pkg;

  localparam logic [7:0] ACK_OK    = 8'h55;
  localparam logic [7:0] ACK_ERR   = 8'hEE;
  localparam logic [7:0] LAST_CTRL = 8'h0C;
  localparam logic [7:0] SPEED_LO  = 8'h10;
  localparam logic [7:0] SPEED_HI  = 8'h73;
  localparam logic [7:0] SPEED_OFS = 8'h0F;

  // Control byte codes
  localparam logic [3:0] CMD_HEARTBEAT = 4'h0;
  localparam logic [3:0] CMD_AB_FWD    = 4'h1;
  localparam logic [3:0] CMD_AB_REV    = 4'h2;
  localparam logic [3:0] CMD_AB_COAST  = 4'h3;
  localparam logic [3:0] CMD_AB_BRAKE  = 4'h4;
  localparam logic [3:0] CMD_CD_FWD    = 4'h5;
  localparam logic [3:0] CMD_CD_REV    = 4'h6;
  localparam logic [3:0] CMD_CD_COAST  = 4'h7;
  localparam logic [3:0] CMD_CD_BRAKE  = 4'h8;
  localparam logic [3:0] CMD_LED_ON    = 4'h9;
  localparam logic [3:0] CMD_LED_OFF   = 4'hA;
  localparam logic [3:0] CMD_RESERVED  = 4'hB;
  localparam logic [3:0] CMD_ESTOP     = 4'hC;

  typedef logic [1:0] motion_t;
  localparam motion_t MOTION_STOP = 2'd0;
  localparam motion_t MOTION_FWD  = 2'd1;
  localparam motion_t MOTION_REV  = 2'd2;

  localparam logic [6:0] SPEED_RESET = 7'd1;
  localparam logic [8:0] ELAPSED_MAX = 9'h1FF;
  localparam logic [1:0] TOGGLE_MAX  = 2'd3;

  typedef struct packed {
    logic       start;
    logic [1:0] half;   // half period in ms, 500/freq clamped to 1, low two bits
    logic [8:0] dur;    // burst length in ms
  } beep_cfg_t;

  // Decoded effect of one item, decoder to top level
  typedef struct packed {
    logic       ack_valid;
    logic [7:0] ack_byte;
    logic       kick;
    logic       ab_we;
    motion_t    ab_val;
    logic       cd_we;
    motion_t    cd_val;
    logic       ab_stop;
    logic       cd_stop;
    logic       brake;
    logic       speed_we;
    logic [6:0] speed_val;
    logic       led_we;
    logic       led_val;
    beep_cfg_t  beep;
  } dec_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic       watchdog_kick;
    logic       speaker_out;
    logic       led_on;
    logic [6:0] speed_out;
    logic       stop_with_brake;
    logic       cd_stop_pulse;
    logic       ab_stop_pulse;
    motion_t    cd_motion;
    motion_t    ab_motion;
    logic [7:0] ack_byte;
    logic       ack_valid;
  } res_t;

  localparam int RES_W   = $bits(res_t);
  localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

  // Tone burst for each control byte
  function automatic beep_cfg_t ctrl_beep(input logic [3:0] code);
    beep_cfg_t c;
    c = '{start: 1'b1, half: 2'd1, dur: 9'd0};
    case (code)
      CMD_AB_FWD:   c.dur = 9'd150;
      CMD_AB_REV:   c.dur = 9'd150;
      CMD_AB_COAST: c.dur = 9'd80;
      CMD_AB_BRAKE: begin c.half = 2'd2; c.dur = 9'd100; end
      CMD_CD_FWD:   c.dur = 9'd150;
      CMD_CD_REV:   c.dur = 9'd150;
      CMD_CD_COAST: c.dur = 9'd80;
      CMD_CD_BRAKE: begin c.half = 2'd2; c.dur = 9'd100; end
      CMD_LED_ON:   c.dur = 9'd60;
      CMD_LED_OFF:  c.dur = 9'd40;
      CMD_ESTOP:    begin c.half = 2'd2; c.dur = 9'd300; end
      default:      c.start = 1'b0;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/bcd_decode.sv */
// Combinational decode of one registered item into its effects.
// Depends on bcd_pkg.
module bcd_decode (
  input  logic          is_tick,
  input  logic [7:0]    rx_byte,
  output bcd_pkg::dec_t dec
);

  logic       is_speed;
  logic       is_ctrl;
  logic [7:0] speed_diff;
  logic [3:0] code;

  assign is_speed   = (rx_byte >= bcd_pkg::SPEED_LO) && (rx_byte <= bcd_pkg::SPEED_HI);
  assign is_ctrl    = (rx_byte <= bcd_pkg::LAST_CTRL);
  assign speed_diff = rx_byte - bcd_pkg::SPEED_OFS;
  assign code       = rx_byte[3:0];

  always_comb begin
    dec = '0;
    if (!is_tick) begin
      dec.ack_valid = 1'b1;
      dec.ack_byte  = bcd_pkg::ACK_ERR;
      if (is_speed) begin
        dec.kick      = 1'b1;
        dec.ack_byte  = bcd_pkg::ACK_OK;
        dec.speed_we  = 1'b1;
        dec.speed_val = speed_diff[6:0];
        dec.beep      = '{start: 1'b1, half: 2'd1, dur: 9'd50};
      end else if (is_ctrl) begin
        dec.kick     = 1'b1;
        dec.ack_byte = (code == bcd_pkg::CMD_RESERVED) ? bcd_pkg::ACK_ERR : bcd_pkg::ACK_OK;
        dec.beep     = bcd_pkg::ctrl_beep(code);
        case (code)
          bcd_pkg::CMD_AB_FWD: begin
            dec.ab_we = 1'b1; dec.ab_val = bcd_pkg::MOTION_FWD;
          end
          bcd_pkg::CMD_AB_REV: begin
            dec.ab_we = 1'b1; dec.ab_val = bcd_pkg::MOTION_REV;
          end
          bcd_pkg::CMD_AB_COAST: begin
            dec.ab_we = 1'b1; dec.ab_stop = 1'b1;
          end
          bcd_pkg::CMD_AB_BRAKE: begin
            dec.ab_we = 1'b1; dec.ab_stop = 1'b1; dec.brake = 1'b1;
          end
          bcd_pkg::CMD_CD_FWD: begin
            dec.cd_we = 1'b1; dec.cd_val = bcd_pkg::MOTION_FWD;
          end
          bcd_pkg::CMD_CD_REV: begin
            dec.cd_we = 1'b1; dec.cd_val = bcd_pkg::MOTION_REV;
          end
          bcd_pkg::CMD_CD_COAST: begin
            dec.cd_we = 1'b1; dec.cd_stop = 1'b1;
          end
          bcd_pkg::CMD_CD_BRAKE: begin
            dec.cd_we = 1'b1; dec.cd_stop = 1'b1; dec.brake = 1'b1;
          end
          bcd_pkg::CMD_LED_ON: begin
            dec.led_we = 1'b1; dec.led_val = 1'b1;
          end
          bcd_pkg::CMD_LED_OFF: begin
            dec.led_we = 1'b1; dec.led_val = 1'b0;
          end
          bcd_pkg::CMD_ESTOP: begin
            dec.ab_we = 1'b1; dec.cd_we = 1'b1;
            dec.ab_stop = 1'b1; dec.cd_stop = 1'b1; dec.brake = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

/* hw/rtl/bcd_beeper.sv */
// Tone burst generator: half period and duration counters, speaker level.
// Depends on bcd_pkg.
module bcd_beeper (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               is_tick,
  input  bcd_pkg::beep_cfg_t cfg,
  output logic               level_next
);

  logic       active, active_next;
  logic       level;
  logic [1:0] half_period, half_period_next;
  logic [8:0] duration, duration_next;
  logic [8:0] elapsed, elapsed_next;
  logic [1:0] since_toggle, since_toggle_next;
  logic [8:0] el_inc;
  logic [1:0] st_inc;

  assign el_inc = (elapsed == bcd_pkg::ELAPSED_MAX) ? elapsed : elapsed + 9'd1;
  assign st_inc = (since_toggle == bcd_pkg::TOGGLE_MAX) ? since_toggle : since_toggle + 2'd1;

  always_comb begin
    active_next       = active;
    level_next        = level;
    half_period_next  = half_period;
    duration_next     = duration;
    elapsed_next      = elapsed;
    since_toggle_next = since_toggle;
    if (cfg.start) begin
      half_period_next  = cfg.half;
      duration_next     = cfg.dur;
      elapsed_next      = '0;
      since_toggle_next = '0;
      active_next       = 1'b1;
      level_next        = 1'b1;
    end else if (is_tick && active) begin
      elapsed_next = el_inc;
      if (el_inc >= duration) begin
        // end of burst: drop the speaker
        level_next  = 1'b0;
        active_next = 1'b0;
      end else if (st_inc >= half_period) begin
        level_next        = ~level;
        since_toggle_next = '0;
      end else begin
        since_toggle_next = st_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      level        <= 1'b0;
      half_period  <= '0;
      duration     <= '0;
      elapsed      <= '0;
      since_toggle <= '0;
    end else if (advance) begin
      active       <= active_next;
      level        <= level_next;
      half_period  <= half_period_next;
      duration     <= duration_next;
      elapsed      <= elapsed_next;
      since_toggle <= since_toggle_next;
    end
  end

endmodule

/* hw/rtl/byte_command_decoder_with_beeper.sv */
// Top level of the byte command decoder with tone-burst beeper.
// Depends on bcd_pkg, bcd_decode and bcd_beeper.

// Takes one transaction per clock on the slave side: a command byte (s_tuser
// low) or a millisecond tick (s_tuser high), and returns exactly one result
// transaction for each on the master side. Sustained rate is one item per
// cycle while results are taken; an item passes through the input register
// and then the result register, with the decode and all state updates done
// in a single combinational pass between the two. The input register can
// still take an item while a result waits for m_tready; only when both
// registers are full and the result is not taken does s_tready drop. The
// result carries the motion, speed, LED and speaker levels as they stand
// after the item, plus the acknowledge byte, stop pulses and watchdog kick
// for that item. No configuration, no clearing pass after reset.
module byte_command_decoder_with_beeper (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,  // [7:0] rx_byte
  input  logic                         s_tuser,  // [0] command (1 = tick)
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [0] ack_valid, [8:1] ack_byte, [10:9] ab_motion, [12:11] cd_motion,
  // [13] ab_stop_pulse, [14] cd_stop_pulse, [15] stop_with_brake,
  // [22:16] speed_out, [23] led_on, [24] speaker_out, [25] watchdog_kick
  output logic [bcd_pkg::TDATA_W-1:0]  m_tdata
);

  // Input register
  logic       in_valid;
  logic       in_tick;
  logic [7:0] in_byte;

  // Persistent state
  bcd_pkg::motion_t ab_motion, ab_motion_next;
  bcd_pkg::motion_t cd_motion, cd_motion_next;
  logic [6:0]       speed, speed_next;
  logic             led, led_next;

  // Result register
  logic          out_valid;
  bcd_pkg::res_t res;
  bcd_pkg::res_t res_next;

  bcd_pkg::dec_t dec;
  logic          speaker_next;
  logic          advance;

  // Move the registered item into the result register when it has room
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(bcd_pkg::TDATA_W - bcd_pkg::RES_W){1'b0}}, res};

  bcd_decode u_decode (
    .is_tick (in_tick),
    .rx_byte (in_byte),
    .dec     (dec)
  );

  bcd_beeper u_beeper (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .is_tick    (in_tick),
    .cfg        (dec.beep),
    .level_next (speaker_next)
  );

  // Apply the decoded writes to the held levels
  always_comb begin
    ab_motion_next = dec.ab_we    ? dec.ab_val    : ab_motion;
    cd_motion_next = dec.cd_we    ? dec.cd_val    : cd_motion;
    speed_next     = dec.speed_we ? dec.speed_val : speed;
    led_next       = dec.led_we   ? dec.led_val   : led;

    res_next.ack_valid       = dec.ack_valid;
    res_next.ack_byte        = dec.ack_byte;
    res_next.ab_motion       = ab_motion_next;
    res_next.cd_motion       = cd_motion_next;
    res_next.ab_stop_pulse   = dec.ab_stop;
    res_next.cd_stop_pulse   = dec.cd_stop;
    res_next.stop_with_brake = dec.brake;
    res_next.speed_out       = speed_next;
    res_next.led_on          = led_next;
    res_next.speaker_out     = speaker_next;
    res_next.watchdog_kick   = dec.kick;
  end

  // Input register: hold while the result side is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_tick <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  // State registers advance with each item that moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      ab_motion <= bcd_pkg::MOTION_STOP;
      cd_motion <= bcd_pkg::MOTION_STOP;
      speed     <= bcd_pkg::SPEED_RESET;
      led       <= 1'b0;
    end else if (advance) begin
      ab_motion <= ab_motion_next;
      cd_motion <= cd_motion_next;
      speed     <= speed_next;
      led       <= led_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  // The slave side only stalls when both registers are full and blocked
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled without a blocked result");

  // A stop pulse always leaves its channel stopped
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (res.ab_stop_pulse || res.cd_stop_pulse)) |->
      ((!res.ab_stop_pulse || res.ab_motion == bcd_pkg::MOTION_STOP) &&
       (!res.cd_stop_pulse || res.cd_motion == bcd_pkg::MOTION_STOP)))
    else $error("stop pulse with channel still moving");

  // Tick results carry no acknowledge, pulse or kick
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ack_valid) |->
      (res.ack_byte == 8'h00 && !res.ab_stop_pulse && !res.cd_stop_pulse &&
       !res.stop_with_brake && !res.watchdog_kick))
    else $error("tick result with command fields set");

  // Speed level stays within its range
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res.speed_out >= 7'd1 && res.speed_out <= 7'd100))
    else $error("speed level out of range");
`endif

endmodule

/* verif/byte_command_decoder_with_beeper_tb.sv */
// Testbench for byte_command_decoder_with_beeper: directed and random command/tick
// traffic checked against an in-bench predictor. Needs bcd_pkg and the RTL only.
`timescale 1ns / 1ps

module byte_command_decoder_with_beeper_tb;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Slave side: one transaction is a command byte or a millisecond tick
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata  = 8'h00;  // [7:0] rx_byte
  logic                          s_tuser  = 1'b0;   // [0] command (1 = tick)
  // Master side: one result transaction per input transaction
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  // [0] ack_valid, [8:1] ack_byte, [10:9] ab_motion, [12:11] cd_motion,
  // [13] ab_stop_pulse, [14] cd_stop_pulse, [15] stop_with_brake,
  // [22:16] speed_out, [23] led_on, [24] speaker_out, [25] watchdog_kick
  logic [bcd_pkg::TDATA_W-1:0]   m_tdata;

  byte_command_decoder_with_beeper dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Idle rates in percent; the test sequence changes them between phases
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Bookkeeping for the summary and the verdict
  int unsigned mismatch_count = 0;
  int unsigned commands_sent  = 0;
  int unsigned ticks_sent     = 0;
  int unsigned bursts_started = 0;
  int unsigned bursts_ended   = 0;
  int unsigned results_seen   = 0;

  // Results predicted for accepted items, oldest first
  bcd_pkg::res_t pending_results[$];

  // ---------------------------------------------------------------------------
  // Shadow copy of the block state
  // ---------------------------------------------------------------------------
  bcd_pkg::motion_t shadow_ab_motion;
  bcd_pkg::motion_t shadow_cd_motion;
  logic [6:0]       shadow_speed;
  logic             shadow_led;
  logic             shadow_beep_on;
  logic             shadow_speaker;
  logic [1:0]       shadow_half;
  logic [8:0]       shadow_dur;
  logic [8:0]       shadow_elapsed;
  logic [1:0]       shadow_since;

  task automatic reset_shadow();
    shadow_ab_motion = bcd_pkg::MOTION_STOP;
    shadow_cd_motion = bcd_pkg::MOTION_STOP;
    shadow_speed     = bcd_pkg::SPEED_RESET;
    shadow_led       = 1'b0;
    shadow_beep_on   = 1'b0;
    shadow_speaker   = 1'b0;
    shadow_half      = 2'd0;
    shadow_dur       = 9'd0;
    shadow_elapsed   = 9'd0;
    shadow_since     = 2'd0;
  endtask

  // Tone frequency (Hz) and burst length (ms) of a control byte; 0 means silent
  function automatic void tone_for_code(input logic [3:0] code,
                                        output int unsigned freq,
                                        output int unsigned dur);
    freq = 0;
    dur  = 0;
    case (code)
      bcd_pkg::CMD_AB_FWD:   begin freq = 500;  dur = 150; end
      bcd_pkg::CMD_AB_REV:   begin freq = 400;  dur = 150; end
      bcd_pkg::CMD_AB_COAST: begin freq = 300;  dur = 80;  end
      bcd_pkg::CMD_AB_BRAKE: begin freq = 200;  dur = 100; end
      bcd_pkg::CMD_CD_FWD:   begin freq = 600;  dur = 150; end
      bcd_pkg::CMD_CD_REV:   begin freq = 550;  dur = 150; end
      bcd_pkg::CMD_CD_COAST: begin freq = 350;  dur = 80;  end
      bcd_pkg::CMD_CD_BRAKE: begin freq = 250;  dur = 100; end
      bcd_pkg::CMD_LED_ON:   begin freq = 1000; dur = 60;  end
      bcd_pkg::CMD_LED_OFF:  begin freq = 900;  dur = 40;  end
      bcd_pkg::CMD_ESTOP:    begin freq = 200;  dur = 300; end
      default:      ;
    endcase
  endfunction

  // Restart the tone burst; half period is 500/freq, never below one tick
  function automatic void restart_burst(input int unsigned freq, input int unsigned dur);
    int unsigned half;
    if (freq == 0 || dur == 0) return;
    half = 500 / freq;
    if (half < 1) half = 1;
    shadow_half    = half[1:0];
    shadow_dur     = dur[8:0];
    shadow_elapsed = 9'd0;
    shadow_since   = 2'd0;
    shadow_beep_on = 1'b1;
    shadow_speaker = 1'b1;
    bursts_started++;
  endfunction

  // Advance the burst by one millisecond
  function automatic void advance_burst();
    if (!shadow_beep_on) return;
    if (shadow_elapsed != bcd_pkg::ELAPSED_MAX) shadow_elapsed++;
    if (shadow_elapsed >= shadow_dur) begin
      shadow_speaker = 1'b0;
      shadow_beep_on = 1'b0;
      bursts_ended++;
      return;
    end
    if (shadow_since != bcd_pkg::TOGGLE_MAX) shadow_since++;
    if (shadow_since >= shadow_half) begin
      shadow_speaker = ~shadow_speaker;
      shadow_since   = 2'd0;
    end
  endfunction

  // Update the shadow state with one item and return the result it causes
  function automatic bcd_pkg::res_t predict_result(input logic is_tick,
                                                   input logic [7:0] rx_val);
    bcd_pkg::res_t r;
    int unsigned   freq;
    int unsigned   dur;
    r = '0;
    if (is_tick) begin
      advance_burst();
    end else begin
      r.ack_valid = 1'b1;
      if (rx_val >= bcd_pkg::SPEED_LO && rx_val <= bcd_pkg::SPEED_HI) begin
        r.watchdog_kick = 1'b1;
        r.ack_byte      = bcd_pkg::ACK_OK;
        shadow_speed    = 7'(rx_val - bcd_pkg::SPEED_OFS);
        restart_burst(800, 50);
      end else if (rx_val <= bcd_pkg::LAST_CTRL) begin
        r.watchdog_kick = 1'b1;
        r.ack_byte      = (rx_val[3:0] == bcd_pkg::CMD_RESERVED) ?
                          bcd_pkg::ACK_ERR : bcd_pkg::ACK_OK;
        case (rx_val[3:0])
          bcd_pkg::CMD_AB_FWD:   shadow_ab_motion = bcd_pkg::MOTION_FWD;
          bcd_pkg::CMD_AB_REV:   shadow_ab_motion = bcd_pkg::MOTION_REV;
          bcd_pkg::CMD_AB_COAST: begin
            shadow_ab_motion = bcd_pkg::MOTION_STOP;
            r.ab_stop_pulse  = 1'b1;
          end
          bcd_pkg::CMD_AB_BRAKE: begin
            shadow_ab_motion  = bcd_pkg::MOTION_STOP;
            r.ab_stop_pulse   = 1'b1;
            r.stop_with_brake = 1'b1;
          end
          bcd_pkg::CMD_CD_FWD:   shadow_cd_motion = bcd_pkg::MOTION_FWD;
          bcd_pkg::CMD_CD_REV:   shadow_cd_motion = bcd_pkg::MOTION_REV;
          bcd_pkg::CMD_CD_COAST: begin
            shadow_cd_motion = bcd_pkg::MOTION_STOP;
            r.cd_stop_pulse  = 1'b1;
          end
          bcd_pkg::CMD_CD_BRAKE: begin
            shadow_cd_motion  = bcd_pkg::MOTION_STOP;
            r.cd_stop_pulse   = 1'b1;
            r.stop_with_brake = 1'b1;
          end
          bcd_pkg::CMD_LED_ON:   shadow_led = 1'b1;
          bcd_pkg::CMD_LED_OFF:  shadow_led = 1'b0;
          bcd_pkg::CMD_ESTOP: begin
            shadow_ab_motion  = bcd_pkg::MOTION_STOP;
            shadow_cd_motion  = bcd_pkg::MOTION_STOP;
            r.ab_stop_pulse   = 1'b1;
            r.cd_stop_pulse   = 1'b1;
            r.stop_with_brake = 1'b1;
          end
          default: ;
        endcase
        tone_for_code(rx_val[3:0], freq, dur);
        restart_burst(freq, dur);
      end else begin
        r.ack_byte = bcd_pkg::ACK_ERR;
      end
    end
    r.ab_motion   = shadow_ab_motion;
    r.cd_motion   = shadow_cd_motion;
    r.speed_out   = shadow_speed;
    r.led_on      = shadow_led;
    r.speaker_out = shadow_speaker;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving the slave side
  // ---------------------------------------------------------------------------

  // Drive one item at the falling edge, hold it until the transaction completes,
  // then queue its predicted result. Random idle cycles go in front.
  task automatic send_item(input logic is_tick, input logic [7:0] rx_val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= is_tick;
    s_tdata  <= rx_val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_result(is_tick, rx_val));
    if (is_tick) ticks_sent++;
    else commands_sent++;
  endtask

  task automatic send_tick();
    // the byte lane is ignored on ticks; keep it random so every bit moves
    send_item(1'b1, 8'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // Master side: random backpressure and the result check
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    bcd_pkg::res_t got;
    bcd_pkg::res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = bcd_pkg::res_t'(m_tdata[bcd_pkg::RES_W-1:0]);
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", got, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.ack_valid != want.ack_valid)
          report_mismatch("ack_valid", got.ack_valid, want.ack_valid);
        if (got.ack_byte != want.ack_byte)
          report_mismatch("ack_byte", got.ack_byte, want.ack_byte);
        if (got.ab_motion != want.ab_motion)
          report_mismatch("ab_motion", got.ab_motion, want.ab_motion);
        if (got.cd_motion != want.cd_motion)
          report_mismatch("cd_motion", got.cd_motion, want.cd_motion);
        if (got.ab_stop_pulse != want.ab_stop_pulse)
          report_mismatch("ab_stop_pulse", got.ab_stop_pulse, want.ab_stop_pulse);
        if (got.cd_stop_pulse != want.cd_stop_pulse)
          report_mismatch("cd_stop_pulse", got.cd_stop_pulse, want.cd_stop_pulse);
        if (got.stop_with_brake != want.stop_with_brake)
          report_mismatch("stop_with_brake", got.stop_with_brake, want.stop_with_brake);
        if (got.speed_out != want.speed_out)
          report_mismatch("speed_out", got.speed_out, want.speed_out);
        if (got.led_on != want.led_on)
          report_mismatch("led_on", got.led_on, want.led_on);
        if (got.speaker_out != want.speaker_out)
          report_mismatch("speaker_out", got.speaker_out, want.speaker_out);
        if (got.watchdog_kick != want.watchdog_kick)
          report_mismatch("watchdog_kick", got.watchdog_kick, want.watchdog_kick);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ticks straight after reset: nothing may move, both byte-lane extremes
  task automatic test_reset_state();
    send_item(1'b1, 8'h00);
    send_item(1'b1, 8'hFF);
  endtask

  // Every control code in order, reserved code and emergency stop included
  task automatic test_control_codes();
    for (int code = bcd_pkg::CMD_HEARTBEAT; code <= bcd_pkg::CMD_ESTOP; code++)
      send_item(1'b0, 8'(code));
    send_tick();
  endtask

  // Both ends of the speed range
  task automatic test_speed_range();
    send_item(1'b0, bcd_pkg::SPEED_LO);
    send_item(1'b0, bcd_pkg::SPEED_HI);
  endtask

  // Unknown bytes just below and above the speed range and at the top
  task automatic test_unknown_bytes();
    send_item(1'b0, 8'h0D);
    send_item(1'b0, 8'h0F);
    send_item(1'b0, 8'h74);
    send_item(1'b0, 8'h80);
    send_item(1'b0, 8'hFF);
  endtask

  // Mostly well-formed: a command and then a run of ticks, now and then
  // long enough to carry the burst to its end
  function automatic logic [7:0] pick_command_byte();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45) return 8'($urandom_range(bcd_pkg::LAST_CTRL));
    if (sel < 75) return 8'($urandom_range(bcd_pkg::SPEED_HI, bcd_pkg::SPEED_LO));
    if (sel < 85) return 8'($urandom_range(8'h0F, 8'h0D));
    return 8'($urandom_range(255));
  endfunction

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned n_ticks;
    sent = 0;
    while (sent < n_items) begin
      send_item(1'b0, pick_command_byte());
      sent++;
      if (shadow_beep_on && $urandom_range(99) < 15)
        n_ticks = shadow_dur - shadow_elapsed + $urandom_range(3);
      else
        n_ticks = $urandom_range(6);
      repeat (n_ticks) begin
        send_tick();
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_shadow();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender idles rarely, receiver stalls often
    send_idle_pct = 17;
    recv_idle_pct = 69;
    test_reset_state();
    test_control_codes();
    test_speed_range();
    test_unknown_bytes();
    test_random_traffic(360);

    // the other way round
    send_idle_pct = 69;
    recv_idle_pct = 17;
    test_random_traffic(360);

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(360);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (8) @(posedge clk);

    $display("Covered %0d command bytes and %0d ticks, %0d results checked;",
             commands_sent, ticks_sent, results_seen);
    $display("%0d tone bursts started, %0d ran to their end, %0d mismatches.",
             bursts_started, bursts_ended, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog on the whole run; a correct run needs well under a tenth of this
  initial begin
    #1000000;
    $display("Timeout with %0d results still expected", pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
